FILE: rtl/core/plwb_pkg.sv
// shared types, register indexes and saturating helpers for the particle step block
// no dependencies
package plwb_pkg;

    localparam int DIV_BITS = 48;

    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] GRAVITY = -32'sd642253;

    localparam logic [30:0] TIME_STEP_RST       = 31'd1092;
    localparam logic [30:0] PARTICLE_RADIUS_RST = 31'd6554;
    localparam logic [17:0] BOUNCE_IMPULSE_RST  = 18'd98304;
    localparam logic [30:0] WALL_HALF_WIDTH_RST = 31'd163840;

    typedef enum logic [1:0] {
        REG_TIME_STEP       = 2'd0,
        REG_PARTICLE_RADIUS = 2'd1,
        REG_BOUNCE_IMPULSE  = 2'd2,
        REG_WALL_HALF_WIDTH = 2'd3
    } reg_index_t;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic        [30:0] mass;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } result_t;

    typedef struct packed {
        vec3_t pos;
        vec3_t vel;
    } side_t;

    function automatic logic [31:0] sat33(input logic signed [32:0] x);
        logic [31:0] r;
        if (x > 33'sd2147483647)
            r = INT_MAX;
        else if (x < -33'sd2147483648)
            r = INT_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    // q16.16 product: floor shift by 16, then saturate
    function automatic logic [31:0] sat_shift(input logic signed [63:0] p);
        logic signed [47:0] s;
        logic [31:0] r;
        s = p[63:16];
        if (s > 48'sh0000_7fff_ffff)
            r = INT_MAX;
        else if (s < -48'sh0000_8000_0000)
            r = INT_MIN;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/plwb_div.sv
// pipelined q16.16 divider, three lanes of force by one mass, one quotient bit per stage
// depends on plwb_pkg
module plwb_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  plwb_pkg::vec3_t       force_in,
    input  logic [30:0]           mass,
    input  plwb_pkg::side_t       side_in,
    output logic                  out_valid,
    output plwb_pkg::vec3_t       quot,
    output plwb_pkg::side_t       side_out
);

    localparam int NS = plwb_pkg::DIV_BITS;

    logic                         vld_reg  [0:NS];
    logic [NS-1:0]                nq_reg   [0:NS][3];
    logic [30:0]                  rem_reg  [0:NS][3];
    logic [2:0]                   neg_reg  [0:NS];
    logic [2:0]                   zf_reg   [0:NS];
    logic [30:0]                  den_reg  [0:NS];
    plwb_pkg::side_t              side_reg [0:NS];

    logic                         out_valid_reg;
    plwb_pkg::vec3_t              quot_reg;
    plwb_pkg::side_t              side_out_reg;
    plwb_pkg::vec3_t              quot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nq_reg[0][i]  <= {(force_in[i][31] ? (32'd0 - force_in[i]) : force_in[i]), 16'd0};
            rem_reg[0][i] <= '0;
            neg_reg[0][i] <= force_in[i][31];
            zf_reg[0][i]  <= (force_in[i] == 32'd0);
        end
        den_reg[0]  <= mass;
        side_reg[0] <= side_in;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [31:0]   tmp [3];
        logic          ge  [3];
        logic [31:0]   dif [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                tmp[i] = {rem_reg[k][i], nq_reg[k][i][NS-1]};
                ge[i]  = (tmp[i] >= {1'b0, den_reg[k]});
                dif[i] = tmp[i] - {1'b0, den_reg[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[k+1][i] <= ge[i] ? dif[i][30:0] : tmp[i][30:0];
                nq_reg[k+1][i]  <= {nq_reg[k][i][NS-2:0], ge[i]};
            end
            neg_reg[k+1]  <= neg_reg[k];
            zf_reg[k+1]   <= zf_reg[k];
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    // sign and saturation of the magnitude quotient
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zf_reg[NS][i])
                quot_next[i] = 32'd0;
            else if (neg_reg[NS][i])
                quot_next[i] = (nq_reg[NS][i] > 48'h0000_8000_0000) ? plwb_pkg::INT_MIN
                             : (32'd0 - nq_reg[NS][i][31:0]);
            else
                quot_next[i] = (nq_reg[NS][i] > 48'h0000_7fff_ffff) ? plwb_pkg::INT_MAX
                             : nq_reg[NS][i][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        side_out_reg <= side_reg[NS];
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;
    assign side_out  = side_out_reg;

`ifndef SYNTHESIS
    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && zf_reg[NS][0] |=> quot_reg[0] == 32'd0)
        else $error("zero force lane gave nonzero quotient");
    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && !neg_reg[NS][1] |=> !quot_reg[1][31])
        else $error("nonnegative force gave negative quotient");
    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && neg_reg[NS][2] |=> quot_reg[2][31] || quot_reg[2] == 32'd0)
        else $error("negative force gave positive quotient");
`endif

endmodule

FILE: rtl/core/particle_leapfrog_wall_bounce_top.sv
// top level of the particle leapfrog step with floor and side wall bounce
// depends on plwb_pkg and plwb_div
//
// usage
// - one particle beat is taken at each rising edge with start high and busy low;
//   busy is always low, so a particle may enter in every cycle
// - the result beat stands on result for one cycle with done high; the receiver
//   cannot hold it off and must take it in that cycle
// - throughput one particle per cycle; each particle passes the 48 stage
//   force / mass divider (one quotient bit per stage) and then 9 arithmetic
//   stages before its result beat comes out with done high
// - registers are written through wr_en, wr_index and wr_data at any edge with
//   wr_en high; write them only while no particle is in flight
// - reset clears all valid bits, so nothing in flight survives, and loads the
//   register defaults: step 1/60, radius 0.1, impulse 1.5, half width 2.5
module particle_leapfrog_wall_bounce_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  plwb_pkg::item_t      item,
    output logic                 done,
    output plwb_pkg::result_t    result,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [30:0]          wr_data
);

    logic [30:0] time_step_reg;
    logic [30:0] particle_radius_reg;
    logic [17:0] bounce_impulse_reg;
    logic [30:0] wall_half_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg       <= plwb_pkg::TIME_STEP_RST;
            particle_radius_reg <= plwb_pkg::PARTICLE_RADIUS_RST;
            bounce_impulse_reg  <= plwb_pkg::BOUNCE_IMPULSE_RST;
            wall_half_width_reg <= plwb_pkg::WALL_HALF_WIDTH_RST;
        end
        else if (wr_en)
        begin
            unique case (plwb_pkg::reg_index_t'(wr_index))
                plwb_pkg::REG_TIME_STEP:       time_step_reg       <= wr_data;
                plwb_pkg::REG_PARTICLE_RADIUS: particle_radius_reg <= wr_data;
                plwb_pkg::REG_BOUNCE_IMPULSE:  bounce_impulse_reg  <= wr_data[17:0];
                plwb_pkg::REG_WALL_HALF_WIDTH: wall_half_width_reg <= wr_data;
            endcase
        end
    end

    logic [29:0]              hdt;
    logic signed [32:0]       r33;
    logic signed [32:0]       w33;
    logic signed [32:0]       lo33;
    logic signed [32:0]       hi33;

    assign hdt  = time_step_reg[30:1];
    assign r33  = $signed({2'b00, particle_radius_reg});
    assign w33  = $signed({2'b00, wall_half_width_reg});
    assign lo33 = r33 - w33;
    assign hi33 = w33 - r33;

    assign busy = 1'b0;

    logic            accept;
    plwb_pkg::vec3_t force_in;
    plwb_pkg::side_t side_in;
    logic            dv;
    plwb_pkg::vec3_t quot;
    plwb_pkg::side_t side_d;

    assign accept      = start && !busy;
    assign force_in[0] = item.force_x;
    assign force_in[1] = item.force_y;
    assign force_in[2] = item.force_z;
    assign side_in.pos = {item.pos_x, item.pos_y, item.pos_z};
    assign side_in.vel = {item.vel_x, item.vel_y, item.vel_z};

    plwb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .force_in (force_in),
        .mass     (item.mass),
        .side_in  (side_in),
        .out_valid(dv),
        .quot     (quot),
        .side_out (side_d)
    );

    // side_in packs x in the top lane, so index 2 is x, 1 is y, 0 is z for pos/vel;
    // force_in uses index 0 for x, so the acceleration is flipped into the same order
    logic [9:1] vld_reg;

    plwb_pkg::vec3_t a1_reg, p1_reg, v1_reg;
    plwb_pkg::vec3_t ah2_reg, p2_reg, v2_reg;
    plwb_pkg::vec3_t ah3_reg, p3_reg, v3_reg;
    plwb_pkg::vec3_t pd4_reg, ah4_reg, p4_reg, v4_reg;
    plwb_pkg::vec3_t p5_reg, v5_reg;
    plwb_pkg::vec3_t p6_reg, v6_reg;
    logic [31:0]     kvx6_reg, kvy6_reg;
    logic            hy6_reg, hl6_reg;
    logic [31:0]     lo6_reg;
    plwb_pkg::vec3_t p7_reg, v7_reg;
    logic            hr7_reg;
    logic [31:0]     hi7_reg;
    plwb_pkg::vec3_t p8_reg, v8_reg;
    logic [31:0]     kvx8_reg;
    logic            hr8_reg;
    plwb_pkg::result_t res_reg;

    plwb_pkg::vec3_t a1_next, ah2_next, v3_next, pd4_next, p5_next, v5_next;
    plwb_pkg::vec3_t p6_next, p7_next, v7_next;
    logic            hy6_next, hl6_next, hr7_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[8:1], dv};
    end

    always_comb
    begin
        // acceleration with gravity on y
        a1_next[2] = quot[0];
        a1_next[1] = plwb_pkg::sat33($signed(quot[1]) + plwb_pkg::GRAVITY);
        a1_next[0] = quot[2];
        for (int i = 0; i < 3; i++)
        begin
            ah2_next[i] = plwb_pkg::sat_shift($signed(a1_reg[i]) * $signed({1'b0, hdt}));
            v3_next[i]  = plwb_pkg::sat33($signed(v2_reg[i]) + $signed(ah2_reg[i]));
            pd4_next[i] = plwb_pkg::sat_shift($signed(v3_reg[i])
                                              * $signed({1'b0, time_step_reg}));
            p5_next[i]  = plwb_pkg::sat33($signed(p4_reg[i]) + $signed(pd4_reg[i]));
            v5_next[i]  = plwb_pkg::sat33($signed(v4_reg[i]) + $signed(ah4_reg[i]));
        end
        // floor and left wall
        hy6_next   = $signed(p5_reg[1]) < r33;
        hl6_next   = $signed(p5_reg[2]) < lo33;
        p6_next    = p5_reg;
        if (hy6_next)
            p6_next[1] = r33[31:0];
        if (hl6_next)
            p6_next[2] = lo33[31:0];
        // apply floor and left bounce, right wall test
        v7_next = v6_reg;
        if (hy6_reg)
            v7_next[1] = plwb_pkg::sat33($signed(v6_reg[1]) - $signed(kvy6_reg));
        if (hl6_reg)
            v7_next[2] = plwb_pkg::sat33($signed(v6_reg[2]) - $signed(kvx6_reg));
        hr7_next = $signed(p6_reg[2]) > hi33;
        p7_next  = p6_reg;
        if (hr7_next)
            p7_next[2] = hi33[31:0];
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= a1_next;
        p1_reg   <= side_d.pos;
        v1_reg   <= side_d.vel;

        ah2_reg  <= ah2_next;
        p2_reg   <= p1_reg;
        v2_reg   <= v1_reg;

        ah3_reg  <= ah2_reg;
        p3_reg   <= p2_reg;
        v3_reg   <= v3_next;

        pd4_reg  <= pd4_next;
        ah4_reg  <= ah3_reg;
        p4_reg   <= p3_reg;
        v4_reg   <= v3_reg;

        p5_reg   <= p5_next;
        v5_reg   <= v5_next;

        p6_reg   <= p6_next;
        v6_reg   <= v5_reg;
        hy6_reg  <= hy6_next;
        hl6_reg  <= hl6_next;
        lo6_reg  <= lo33[31:0];
        kvy6_reg <= plwb_pkg::sat_shift($signed({1'b0, bounce_impulse_reg})
                                        * $signed(v5_reg[1]));
        kvx6_reg <= plwb_pkg::sat_shift($signed({1'b0, bounce_impulse_reg})
                                        * $signed(v5_reg[2]));

        p7_reg   <= p7_next;
        v7_reg   <= v7_next;
        hr7_reg  <= hr7_next;
        hi7_reg  <= hi33[31:0];

        p8_reg   <= p7_reg;
        v8_reg   <= v7_reg;
        hr8_reg  <= hr7_reg;
        kvx8_reg <= plwb_pkg::sat_shift($signed({1'b0, bounce_impulse_reg})
                                        * $signed(v7_reg[2]));

        res_reg.new_pos_x <= p8_reg[2];
        res_reg.new_pos_y <= p8_reg[1];
        res_reg.new_pos_z <= p8_reg[0];
        res_reg.new_vel_x <= hr8_reg ? plwb_pkg::sat33($signed(v8_reg[2]) - $signed(kvx8_reg))
                                     : v8_reg[2];
        res_reg.new_vel_y <= v8_reg[1];
        res_reg.new_vel_z <= v8_reg[0];
    end

    assign done   = vld_reg[9];
    assign result = res_reg;

`ifndef SYNTHESIS
    a_floor_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && hy6_reg |-> $signed(p6_reg[1]) >= 0)
        else $error("floor clamp left particle below floor");
    a_left_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && hl6_reg |-> p6_reg[2] == lo6_reg)
        else $error("left wall clamp did not place particle on the wall");
    a_right_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[7] |-> $signed(p7_reg[2]) <= $signed(hi7_reg))
        else $error("particle beyond right wall after clamp");
`endif

endmodule

FILE: test/plwb_checker.sv
// checker for the particle leapfrog step block: predicts each result beat and compares it
// depends on plwb_pkg; watches the particle, result and register write channels
module plwb_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  plwb_pkg::item_t      item,
    input  logic                 done,
    input  plwb_pkg::result_t    result,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [30:0]          wr_data,
    output int                   errors,
    output int                   pending
);
    import plwb_pkg::*;

    logic [30:0] dt_q;
    logic [30:0] radius_q;
    logic [17:0] impulse_q;
    logic [30:0] half_width_q;
    result_t     expected_q[$];

    function automatic longint clamp32(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    // exact product, floor shift by 16
    function automatic longint fix_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> 16);
    endfunction

    function automatic longint fix_div(input longint num, input longint den);
        longint r;
        if (den == 0)
            r = (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 64'sd0);
        else
            r = clamp32((num * 65536) / den);
        return r;
    endfunction

    function automatic longint rebound(input longint v);
        return clamp32(v - fix_mul(longint'(impulse_q), v));
    endfunction

    function automatic result_t particle_step(input item_t it);
        longint p[3];
        longint v[3];
        longint a[3];
        longint f[3];
        longint dt;
        longint hdt;
        longint r;
        longint w;
        result_t res;
        dt = longint'(dt_q);
        hdt = dt / 2;
        r = longint'(radius_q);
        w = longint'(half_width_q);
        p[0] = longint'(it.pos_x);
        p[1] = longint'(it.pos_y);
        p[2] = longint'(it.pos_z);
        v[0] = longint'(it.vel_x);
        v[1] = longint'(it.vel_y);
        v[2] = longint'(it.vel_z);
        f[0] = longint'(it.force_x);
        f[1] = longint'(it.force_y);
        f[2] = longint'(it.force_z);
        for (int i = 0; i < 3; i++)
            a[i] = fix_div(f[i], longint'(it.mass));
        a[1] = clamp32(a[1] + longint'(GRAVITY));
        for (int i = 0; i < 3; i++)
        begin
            v[i] = clamp32(v[i] + fix_mul(a[i], hdt));
            p[i] = clamp32(p[i] + fix_mul(v[i], dt));
            v[i] = clamp32(v[i] + fix_mul(a[i], hdt));
        end
        if (p[1] < r)
        begin
            p[1] = r;
            v[1] = rebound(v[1]);
        end
        if (p[0] < r - w)
        begin
            p[0] = r - w;
            v[0] = rebound(v[0]);
        end
        if (p[0] > w - r)
        begin
            p[0] = w - r;
            v[0] = rebound(v[0]);
        end
        res.new_pos_x = p[0][31:0];
        res.new_pos_y = p[1][31:0];
        res.new_pos_z = p[2][31:0];
        res.new_vel_x = v[0][31:0];
        res.new_vel_y = v[1][31:0];
        res.new_vel_z = v[2][31:0];
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_q <= TIME_STEP_RST;
            radius_q <= PARTICLE_RADIUS_RST;
            impulse_q <= BOUNCE_IMPULSE_RST;
            half_width_q <= WALL_HALF_WIDTH_RST;
            expected_q.delete();
            errors <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected result beat: %h", $time, result);
                    errors <= errors + 1;
                end
                else
                begin
                    result_t exp_r;
                    exp_r = expected_q.pop_front();
                    if (exp_r !== result)
                    begin
                        $display("%0t mismatch: expected %h actual %h", $time, exp_r, result);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(particle_step(item));
            if (wr_en)
            begin
                case (reg_index_t'(wr_index))
                    REG_TIME_STEP:       dt_q <= wr_data;
                    REG_PARTICLE_RADIUS: radius_q <= wr_data;
                    REG_BOUNCE_IMPULSE:  impulse_q <= wr_data[17:0];
                    REG_WALL_HALF_WIDTH: half_width_q <= wr_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: test/tb.sv
// testbench top for the particle leapfrog step block: makes particle beats and register writes
// depends on plwb_pkg, particle_leapfrog_wall_bounce_top and plwb_checker
module tb;
    import plwb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [30:0] wr_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          idle_pct;

    particle_leapfrog_wall_bounce_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data)
    );

    plwb_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2: v = $urandom_range(0, 600000) - 300000;
            3: v = $urandom_range(0, 40000) - 20000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic item_t random_particle();
        item_t it;
        it.pos_x = pick32();
        it.pos_y = pick32();
        it.pos_z = pick32();
        it.vel_x = pick32();
        it.vel_y = pick32();
        it.vel_z = pick32();
        it.force_x = pick32();
        it.force_y = pick32();
        it.force_z = pick32();
        case ($urandom_range(0, 4))
            0: it.mass = 31'd0;
            1: it.mass = 31'h7fff_ffff;
            2: it.mass = 31'($urandom_range(1, 200000));
            default: it.mass = 31'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_particle(input item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [30:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [30:0] ts, input logic [30:0] rad,
                             input logic [30:0] imp, input logic [30:0] hw);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_PARTICLE_RADIUS, rad);
        write_reg(REG_BOUNCE_IMPULSE, imp);
        write_reg(REG_WALL_HALF_WIDTH, hw);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        item_t it;
        int pcts[4];
        pcts = '{0, 80, 0, 22};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero mass, wall contacts
        it = '0;
        send_particle(it);
        it.mass = 31'd65536;
        send_particle(it);
        it.force_x = 32'h7fff_ffff; it.force_y = 32'h8000_0000; it.mass = 31'd0;
        send_particle(it);
        it = '1;
        send_particle(it);
        it = '0; it.pos_x = 32'h8000_0000; it.pos_y = 32'h8000_0000; it.mass = 31'd1;
        it.vel_x = 32'h7fff_ffff; it.vel_y = 32'h8000_0000;
        send_particle(it);
        it.pos_x = 32'h7fff_ffff; it.vel_x = 32'h8000_0000; it.vel_y = 32'h7fff_ffff;
        send_particle(it);
        it = '0; it.pos_x = 32'sd200000; it.pos_y = 32'sd100; it.vel_x = 32'sd70000;
        it.mass = 31'd65536;
        send_particle(it);
        it.pos_x = -32'sd200000; it.vel_x = -32'sd70000;
        send_particle(it);
        it.mass = 31'h7fff_ffff; it.force_z = 32'h7fff_ffff;
        send_particle(it);
        drain();

        // radius wider than the walls, impulse of 2.0 in q16.16
        write_all(31'h7fff_ffff, 31'd400000, 31'd131072, 31'd0);
        for (int i = 0; i < 8; i++)
            send_particle(random_particle());
        drain();
        write_all(31'd0, 31'd0, 31'd0, 31'h7fff_ffff);
        for (int i = 0; i < 8; i++)
            send_particle(random_particle());
        drain();
        write_all(31'h7fff_ffff, 31'h7fff_ffff, 31'h3ffff, 31'h7fff_ffff);
        for (int i = 0; i < 6; i++)
            send_particle(random_particle());
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct = pcts[ph % 4];
            case (ph % 4)
                0: write_all(TIME_STEP_RST, PARTICLE_RADIUS_RST, 31'(BOUNCE_IMPULSE_RST),
                             WALL_HALF_WIDTH_RST);
                1: write_all(31'($urandom_range(0, 100000)), 31'($urandom_range(0, 300000)),
                             31'($urandom_range(0, 131072)), 31'($urandom_range(0, 500000)));
                2: write_all(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
                default: write_all(31'($urandom_range(0, 70000)),
                                   31'($urandom_range(0, 70000)),
                                   31'($urandom_range(60000, 131072)),
                                   31'($urandom_range(0, 300000)));
            endcase
            for (int i = 0; i < 140; i++)
                send_particle(random_particle());
            drain();
        end
        idle_pct = 0;

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/plwb_pkg.sv
rtl/core/plwb_div.sv
rtl/core/particle_leapfrog_wall_bounce_top.sv
test/plwb_checker.sv
test/tb.sv
